### sv/glg_pkg.sv
// Shared constants and types of the grid locator encoder.
package glg_pkg;

  localparam int LatW = 20;
  localparam int LonW = 21;

  localparam int QuarterTurnAs = 324000;
  localparam int HalfTurnAs    = 648000;
  localparam int FullTurnAs    = 1296000;

  localparam int LatFieldAs  = 36000;
  localparam int LatSquareAs = 3600;
  localparam int LatSubAs    = 150;
  localparam int LonFieldAs  = 72000;
  localparam int LonSquareAs = 7200;
  localparam int LonSubAs    = 300;

  localparam int NumFields  = 18;
  localparam int NumSquares = 10;
  localparam int NumSubs    = 24;

  localparam int AsciiUpperA = 65;
  localparam int AsciiZero   = 48;
  localparam int AsciiLowerA = 97;

  typedef struct packed {
    logic            err;
    logic [LatW-1:0] lat_n;
    logic [LonW-1:0] lon_n;
  } norm_t;

endpackage

### sv/glg_norm.sv
// Coordinate normalization: latitude offset and range check, longitude wrap.
module glg_norm import glg_pkg::*; (
  input  logic signed [LatW-1:0] lat_i,
  input  logic signed [LonW-1:0] lon_i,
  output norm_t                  norm_o
);

  logic signed [LatW:0]   lat_s;
  logic signed [LonW+1:0] lon_s;
  logic signed [LonW+1:0] lon_w;

  always_comb begin
    lat_s = (LatW+1)'(lat_i) + (LatW+1)'(QuarterTurnAs);
    lon_s = (LonW+2)'(lon_i) + (LonW+2)'(HalfTurnAs);
    if (lon_s < 0) begin
      lon_w = lon_s + (LonW+2)'(FullTurnAs);
    end else if (lon_s >= (LonW+2)'(FullTurnAs)) begin
      lon_w = lon_s - (LonW+2)'(FullTurnAs);
    end else begin
      lon_w = lon_s;
    end
    norm_o.err   = (lat_s < 0) || (lat_s > (LatW+1)'(2 * QuarterTurnAs));
    norm_o.lat_n = (lat_s == (LatW+1)'(2 * QuarterTurnAs)) ?
                   LatW'(2 * QuarterTurnAs - 1) : lat_s[LatW-1:0];
    norm_o.lon_n = lon_w[LonW-1:0];
  end

endmodule

### sv/glg_cdiv.sv
// Division of a bounded value by a constant through parallel threshold compares.
module glg_cdiv #(
  parameter int unsigned XW  = 20,
  parameter int unsigned DIV = 36000,
  parameter int unsigned NQ  = 18
) (
  input  logic [XW-1:0]         x_i,
  output logic [$clog2(NQ)-1:0] q_o,
  output logic [XW-1:0]         r_o
);

  always_comb begin
    q_o = '0;
    for (int unsigned k = 1; k < NQ; k++) begin
      if (x_i >= XW'(k * DIV)) begin
        q_o = ($clog2(NQ))'(k);
      end
    end
    r_o = x_i - XW'(32'(q_o) * DIV);
  end

endmodule

### sv/latlon_to_grid_locator.sv
// Top level: five-stage pipeline encoding a coordinate pair into a 6-char grid locator.
//
//   channel  dir  tdata fields (low bit up)                      tuser
//   s_axis   in   lat_arcsec[19:0] lon_arcsec[40:20] pad to 48   -
//   m_axis   out  lon_field, lat_field, square_lon, square_lat,  range_error
//                 sub_lon, sub_lat, centre_lat, centre_lon (88)
//
// One request per cycle unless the output stalls; each request passes the stage chain in order:
// normalize, field, square, subsquare, pack.
// Reset clears the stage valid bits only.
// A stage takes a new request whenever it is empty or its successor advances,
// so bubbles close up while the output waits.
module latlon_to_grid_locator import glg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // lat_arcsec, lon_arcsec
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // lon_field_letter, lat_field_letter,
                                      // square_lon_digit, square_lat_digit,
                                      // sub_lon_letter, sub_lat_letter,
                                      // centre_lat_arcsec, centre_lon_arcsec
  output logic [0:0]  m_axis_tuser    // range_error
);

  typedef struct packed {
    norm_t       n;
    logic [4:0]  flat;
    logic [4:0]  flon;
    logic [15:0] rlat;
    logic [16:0] rlon;
  } st2_t;

  typedef struct packed {
    norm_t       n;
    logic [4:0]  flat;
    logic [4:0]  flon;
    logic [3:0]  slat;
    logic [3:0]  slon;
    logic [11:0] rlat;
    logic [12:0] rlon;
  } st3_t;

  typedef struct packed {
    norm_t       n;
    logic [4:0]  flat;
    logic [4:0]  flon;
    logic [3:0]  slat;
    logic [3:0]  slon;
    logic [4:0]  sslat;
    logic [4:0]  sslon;
    logic [7:0]  rlat;
    logic [8:0]  rlon;
  } st4_t;

  typedef struct packed {
    logic            err;
    logic [LonW-1:0] centre_lon;
    logic [LatW-1:0] centre_lat;
    logic [6:0]      sub_lat;
    logic [6:0]      sub_lon;
    logic [5:0]      sq_lat;
    logic [5:0]      sq_lon;
    logic [6:0]      fld_lat;
    logic [6:0]      fld_lon;
  } st5_t;

  logic  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic  en1, en2, en3, en4, en5;
  norm_t norm_d, s1_q;
  st2_t  s2_d, s2_q;
  st3_t  s3_d, s3_q;
  st4_t  s4_d, s4_q;
  st5_t  s5_d, s5_q;

  logic [4:0]      flat2_w;
  logic [4:0]      flon2_w;
  logic [3:0]      slat3_w;
  logic [3:0]      slon3_w;
  logic [4:0]      sslat4_w;
  logic [4:0]      sslon4_w;
  logic [LatW-1:0] rlat2_w;
  logic [LonW-1:0] rlon2_w;
  logic [15:0]     rlat3_w;
  logic [16:0]     rlon3_w;
  logic [11:0]     rlat4_w;
  logic [12:0]     rlon4_w;

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = v5_q;
  assign m_axis_tuser  = s5_q.err;
  assign m_axis_tdata  = {7'b0, s5_q.centre_lon, s5_q.centre_lat, s5_q.sub_lat,
                          s5_q.sub_lon, s5_q.sq_lat, s5_q.sq_lon, s5_q.fld_lat,
                          s5_q.fld_lon};

  glg_norm u_norm (
    .lat_i  (s_axis_tdata[19:0]),
    .lon_i  (s_axis_tdata[40:20]),
    .norm_o (norm_d)
  );

  glg_cdiv #(.XW(LatW), .DIV(LatFieldAs), .NQ(NumFields)) u_fld_lat (
    .x_i (s1_q.lat_n), .q_o (flat2_w), .r_o (rlat2_w)
  );
  glg_cdiv #(.XW(LonW), .DIV(LonFieldAs), .NQ(NumFields)) u_fld_lon (
    .x_i (s1_q.lon_n), .q_o (flon2_w), .r_o (rlon2_w)
  );

  glg_cdiv #(.XW(16), .DIV(LatSquareAs), .NQ(NumSquares)) u_sq_lat (
    .x_i (s2_q.rlat), .q_o (slat3_w), .r_o (rlat3_w)
  );
  glg_cdiv #(.XW(17), .DIV(LonSquareAs), .NQ(NumSquares)) u_sq_lon (
    .x_i (s2_q.rlon), .q_o (slon3_w), .r_o (rlon3_w)
  );

  glg_cdiv #(.XW(12), .DIV(LatSubAs), .NQ(NumSubs)) u_sub_lat (
    .x_i (s3_q.rlat), .q_o (sslat4_w), .r_o (rlat4_w)
  );
  glg_cdiv #(.XW(13), .DIV(LonSubAs), .NQ(NumSubs)) u_sub_lon (
    .x_i (s3_q.rlon), .q_o (sslon4_w), .r_o (rlon4_w)
  );

  always_comb begin
    s2_d.n    = s1_q;
    s2_d.flat = flat2_w;
    s2_d.flon = flon2_w;
    s2_d.rlat = rlat2_w[15:0];
    s2_d.rlon = rlon2_w[16:0];

    s3_d.n    = s2_q.n;
    s3_d.flat = s2_q.flat;
    s3_d.flon = s2_q.flon;
    s3_d.slat = slat3_w;
    s3_d.slon = slon3_w;
    s3_d.rlat = rlat3_w[11:0];
    s3_d.rlon = rlon3_w[12:0];

    s4_d.n     = s3_q.n;
    s4_d.flat  = s3_q.flat;
    s4_d.flon  = s3_q.flon;
    s4_d.slat  = s3_q.slat;
    s4_d.slon  = s3_q.slon;
    s4_d.sslat = sslat4_w;
    s4_d.sslon = sslon4_w;
    s4_d.rlat  = rlat4_w[7:0];
    s4_d.rlon  = rlon4_w[8:0];
  end

  always_comb begin
    s5_d = '0;
    s5_d.err = s4_q.n.err;
    if (!s4_q.n.err) begin
      s5_d.fld_lon    = 7'(AsciiUpperA) + {2'b0, s4_q.flon};
      s5_d.fld_lat    = 7'(AsciiUpperA) + {2'b0, s4_q.flat};
      s5_d.sq_lon     = 6'(AsciiZero) + {2'b0, s4_q.slon};
      s5_d.sq_lat     = 6'(AsciiZero) + {2'b0, s4_q.slat};
      s5_d.sub_lon    = 7'(AsciiLowerA) + {2'b0, s4_q.sslon};
      s5_d.sub_lat    = 7'(AsciiLowerA) + {2'b0, s4_q.sslat};
      s5_d.centre_lat = s4_q.n.lat_n - {12'b0, s4_q.rlat}
                        + LatW'(LatSubAs / 2 - QuarterTurnAs);
      s5_d.centre_lon = s4_q.n.lon_n - {12'b0, s4_q.rlon}
                        + LonW'(LonSubAs / 2 - HalfTurnAs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= norm_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
    if (en5) s5_q <= s5_d;
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("range error result carries nonzero data");

  a_field_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      s5_q.fld_lat >= 7'(AsciiUpperA) && s5_q.fld_lat <= 7'(AsciiUpperA + NumFields - 1) &&
      s5_q.fld_lon >= 7'(AsciiUpperA) && s5_q.fld_lon <= 7'(AsciiUpperA + NumFields - 1))
    else $error("field letter out of range");

  a_sub_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      s5_q.sub_lat <= 7'(AsciiLowerA + NumSubs - 1) &&
      s5_q.sub_lon <= 7'(AsciiLowerA + NumSubs - 1))
    else $error("subsquare letter out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v1_q && v2_q && v3_q && v4_q && v5_q && !m_axis_tready)
    else $error("input stalled with a free stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !en4 |=> v4_q && $stable(s4_q))
    else $error("stalled stage lost its request");

endmodule

### tb/latlon_to_grid_locator_tb.sv
// Self-checking testbench for the six-character grid locator encoder.
module latlon_to_grid_locator_tb import glg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit  = 4000;
  localparam int NumRandom  = 700;
  localparam int LongHold   = 400;
  localparam int HoldAfter  = 200;

  typedef struct packed {
    logic            range_error;
    logic [6:0]      lon_field;
    logic [6:0]      lat_field;
    logic [5:0]      square_lon;
    logic [5:0]      square_lat;
    logic [6:0]      sub_lon;
    logic [6:0]      sub_lat;
    logic [LatW-1:0] centre_lat;
    logic [LonW-1:0] centre_lon;
  } locator_t;

  class grid_scoreboard;
    locator_t    pending_locators[$];
    int unsigned failures;

    function automatic locator_t encode_locator(input logic signed [LatW-1:0] lat,
                                                input logic signed [LonW-1:0] lon);
      int lat_n, lon_n, rem, fld_lat, fld_lon, sq_lat, sq_lon, sub_lat, sub_lon;
      locator_t loc;
      loc = '0;
      lat_n = int'(lat) + QuarterTurnAs;
      if (lat_n < 0 || lat_n > 2 * QuarterTurnAs) begin
        loc.range_error = 1'b1;
        return loc;
      end
      // fold the pole into the topmost subsquare
      if (lat_n == 2 * QuarterTurnAs) lat_n = 2 * QuarterTurnAs - 1;
      lon_n = (int'(lon) + HalfTurnAs) % FullTurnAs;
      if (lon_n < 0) lon_n += FullTurnAs;

      fld_lat = lat_n / LatFieldAs;
      rem     = lat_n % LatFieldAs;
      sq_lat  = rem / LatSquareAs;
      sub_lat = (rem % LatSquareAs) / LatSubAs;
      fld_lon = lon_n / LonFieldAs;
      rem     = lon_n % LonFieldAs;
      sq_lon  = rem / LonSquareAs;
      sub_lon = (rem % LonSquareAs) / LonSubAs;

      loc.lon_field  = 7'(AsciiUpperA + fld_lon);
      loc.lat_field  = 7'(AsciiUpperA + fld_lat);
      loc.square_lon = 6'(AsciiZero + sq_lon);
      loc.square_lat = 6'(AsciiZero + sq_lat);
      loc.sub_lon    = 7'(AsciiLowerA + sub_lon);
      loc.sub_lat    = 7'(AsciiLowerA + sub_lat);
      loc.centre_lat = LatW'(-QuarterTurnAs + fld_lat * LatFieldAs + sq_lat * LatSquareAs
                             + sub_lat * LatSubAs + LatSubAs / 2);
      loc.centre_lon = LonW'(-HalfTurnAs + fld_lon * LonFieldAs + sq_lon * LonSquareAs
                             + sub_lon * LonSubAs + LonSubAs / 2);
      return loc;
    endfunction

    function void note_request(input logic [LatW-1:0] lat, input logic [LonW-1:0] lon);
      pending_locators.push_back(encode_locator(lat, lon));
    endfunction

    function void check_result(input logic [87:0] data, input logic [0:0] user);
      locator_t exp, act;
      act.range_error = user[0];
      act.lon_field   = data[6:0];
      act.lat_field   = data[13:7];
      act.square_lon  = data[19:14];
      act.square_lat  = data[25:20];
      act.sub_lon     = data[32:26];
      act.sub_lat     = data[39:33];
      act.centre_lat  = data[59:40];
      act.centre_lon  = data[80:60];
      if (pending_locators.size() == 0) begin
        failures++;
        if (failures <= 10) $display("ERROR: result with no request pending");
        return;
      end
      exp = pending_locators.pop_front();
      if (act.range_error !== exp.range_error || act.lon_field !== exp.lon_field ||
          act.lat_field !== exp.lat_field || act.square_lon !== exp.square_lon ||
          act.square_lat !== exp.square_lat || act.sub_lon !== exp.sub_lon ||
          act.sub_lat !== exp.sub_lat || act.centre_lat !== exp.centre_lat ||
          act.centre_lon !== exp.centre_lon) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: exp err=%0d loc=%c%c%c%c%c%c lat=%0d lon=%0d",
                   exp.range_error, exp.lon_field, exp.lat_field, exp.square_lon,
                   exp.square_lat, exp.sub_lon, exp.sub_lat,
                   $signed(exp.centre_lat), $signed(exp.centre_lon));
          $display("       got err=%0d loc=%c%c%c%c%c%c lat=%0d lon=%0d",
                   act.range_error, act.lon_field, act.lat_field, act.square_lon,
                   act.square_lat, act.sub_lon, act.sub_lat,
                   $signed(act.centre_lat), $signed(act.centre_lon));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // lat_arcsec, lon_arcsec
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // lon_field_letter, lat_field_letter,
                                    // square_lon_digit, square_lat_digit,
                                    // sub_lon_letter, sub_lat_letter,
                                    // centre_lat_arcsec, centre_lon_arcsec
  logic [0:0]  m_axis_tuser;        // range_error

  grid_scoreboard sb = new();
  int unsigned    results_seen = 0;
  int unsigned    idle_cycles = 0;

  latlon_to_grid_locator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
      results_seen++;
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap(input int idx);
    int r;
    if ((idx / 50) % 3 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function automatic int pick_lat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return int'($urandom_range(0, 2 * QuarterTurnAs)) - QuarterTurnAs;
    if (r < 80) return int'($urandom_range(0, 4320)) * LatSubAs - QuarterTurnAs
                       + int'($urandom_range(0, 2)) - 1;
    if (r < 92) return int'($signed(20'($urandom)));
    case ($urandom_range(0, 3))
      0: return QuarterTurnAs;
      1: return -QuarterTurnAs;
      2: return QuarterTurnAs + 1;
      default: return -QuarterTurnAs - 1;
    endcase
  endfunction

  function automatic int pick_lon();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return int'($urandom_range(0, 2 * HalfTurnAs)) - HalfTurnAs;
    if (r < 80) return int'($urandom_range(0, 4320)) * LonSubAs - HalfTurnAs
                       + int'($urandom_range(0, 2)) - 1;
    return int'($signed(21'($urandom)));
  endfunction

  task automatic send_coord(input int lat, input int lon, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, LonW'(lon), LatW'(lat)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(LatW'(lat), LonW'(lon));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_locators.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int run, gap;
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 20);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = $urandom_range(0, 99);
      gap = (gap < 50) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(15, 50);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int dir_lat[$];
    int dir_lon[$];
    dir_lat = '{-QuarterTurnAs, QuarterTurnAs, QuarterTurnAs + 1, -QuarterTurnAs - 1, 0,
                QuarterTurnAs - 1, 524287, -524288, -400000, 400000, -288000, -288001,
                -QuarterTurnAs + LatSubAs - 1, -QuarterTurnAs + LatSubAs, 3599, 3600,
                QuarterTurnAs, 12345, -QuarterTurnAs, 0, 1, -1};
    dir_lon = '{-HalfTurnAs, HalfTurnAs, 0, -HalfTurnAs - 1, HalfTurnAs - 1, 1048575,
                -1048576, 0, 0, 0, -576000, -576001, -HalfTurnAs + LonSubAs - 1,
                -HalfTurnAs + LonSubAs, 7199, 7200, HalfTurnAs, -1048576, 1048575,
                HalfTurnAs + 1, -1, 648000 + 299};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_lat[i]) send_coord(dir_lat[i], dir_lon[i], (i % 4 == 3) ? 2 : 0);
    drain_results();
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) drain_results();
      send_coord(pick_lat(), pick_lon(), pick_gap(i));
    end
    drain_results();
    repeat (20) @(posedge clk_i);
    sb.failures += sb.pending_locators.size();
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
